/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the bank mapper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* rtl/slbm_pkg.sv */
// Package with the item types and codes of the serial loaded bank mapper.
`default_nettype none

package slbm_pkg;

  // Widths of the configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgPrgCount = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgChrCount = 2'd1;

  // Bus access codes.
  localparam logic [1:0] ActCpuRead  = 2'd0;
  localparam logic [1:0] ActCpuWrite = 2'd1;
  localparam logic [1:0] ActPpuRead  = 2'd2;
  localparam logic [1:0] ActPpuWrite = 2'd3;

  // Targets of a completed serial load, chosen by address bits 14:13.
  localparam logic [1:0] RegControl = 2'd0;
  localparam logic [1:0] RegChrLow  = 2'd1;
  localparam logic [1:0] RegChrHigh = 2'd2;
  localparam logic [1:0] RegPrg     = 2'd3;

  // PRG banking modes held in control bits 3:2.
  localparam logic [1:0] PrgWideA    = 2'd0;
  localparam logic [1:0] PrgWideB    = 2'd1;
  localparam logic [1:0] PrgFixFirst = 2'd2;
  localparam logic [1:0] PrgFixLast  = 2'd3;

  // Serial loader and control reset values.
  localparam logic [4:0] LoadShiftInit = 5'h10;
  localparam logic [4:0] ControlInit   = 5'h1c;
  localparam logic [2:0] LoadBits      = 3'd5;

  // Number of remainder steps, one per bank number bit.
  localparam int unsigned DivSteps = 5;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] bus_addr;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [18:0] mapped_addr;
    logic [1:0]  mirror_mode;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StCalc = 3'b010,
    StDone = 3'b100
  } state_e;

endpackage

`default_nettype wire

/* rtl/serial_loaded_bank_mapper.sv */
// Top level of the serial loaded bank mapper: sequencer, bank registers and remainder unit.
//
// Each accepted item is one bus access and yields exactly one result item.
// The item is decoded in the cycle it is accepted, then a shared compare and
// subtract unit reduces the selected 5-bit bank number modulo the configured
// bank count, one bit per cycle. The result is valid once the last step is
// done and is held until taken; the next item is accepted in the cycle after
// the result is taken, so no new item is accepted while one is in flight.
// CPU writes update the serial loader and bank registers at acceptance, and
// every result carries the mirroring mode after that update. Configuration
// writes are always ready and must only be issued while no item is in flight.
`default_nettype none

`include "assert_macros.svh"

module serial_loaded_bank_mapper (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire  slbm_pkg::in_item_t       in_item_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output slbm_pkg::out_item_t            out_item_o,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire  [slbm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire  [slbm_pkg::CfgDataW-1:0]  cfg_data_i
);

  // Configuration and mapper registers.
  logic [5:0] prg_count_q;
  logic [5:0] chr_count_q;
  logic [4:0] load_shift_q, load_shift_d;
  logic [2:0] load_count_q, load_count_d;
  logic [4:0] control_q, control_d;
  logic [4:0] chr_low_q, chr_low_d;
  logic [4:0] chr_high_q, chr_high_d;
  logic [3:0] prg_sel_q, prg_sel_d;

  // Sequencer and remainder unit registers.
  slbm_pkg::state_e state_q, state_d;
  logic [2:0]  step_q, step_d;
  logic [4:0]  dvd_q, dvd_d;
  logic [6:0]  div_q, div_d;
  logic [6:0]  rem_q, rem_d;
  logic        fixed_q, fixed_d;
  logic [5:0]  fixed_bank_q, fixed_bank_d;
  logic [14:0] offset_q, offset_d;
  logic        chr_q, chr_d;
  logic        hit_q, hit_d;

  logic        in_acc;
  logic        out_acc;
  logic [6:0]  prg_div;
  logic [6:0]  chr_div;
  logic [4:0]  shift_next;
  logic [2:0]  count_next;
  logic [7:0]  trial;
  logic [6:0]  bank;
  logic [20:0] mapped_sum;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign in_stall_o  = (state_q != slbm_pkg::StIdle);
  assign out_valid_o = (state_q == slbm_pkg::StDone);
  assign cfg_ready_o = 1'b1;

  // Effective divisors: a zero PRG count acts as one, the CHR count is doubled into 4 KiB units.
  assign prg_div = (prg_count_q == 6'd0) ? 7'd1 : {1'b0, prg_count_q};
  assign chr_div = {chr_count_q, 1'b0};

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_count_q <= 6'd1;
      chr_count_q <= 6'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == slbm_pkg::CfgPrgCount) begin
        prg_count_q <= cfg_data_i;
      end else if (cfg_index_i == slbm_pkg::CfgChrCount) begin
        chr_count_q <= cfg_data_i;
      end
    end
  end

  // Serial loader and bank register updates on CPU writes to the upper half.
  assign shift_next = {in_item_i.write_data[0], load_shift_q[4:1]};
  assign count_next = load_count_q + 3'd1;

  always_comb begin
    load_shift_d = load_shift_q;
    load_count_d = load_count_q;
    control_d    = control_q;
    chr_low_d    = chr_low_q;
    chr_high_d   = chr_high_q;
    prg_sel_d    = prg_sel_q;
    if (in_acc && in_item_i.action == slbm_pkg::ActCpuWrite && in_item_i.bus_addr[15]) begin
      if (in_item_i.write_data[7]) begin
        load_shift_d = slbm_pkg::LoadShiftInit;
        load_count_d = 3'd0;
        control_d    = control_q | 5'h0c;
      end else if (count_next == slbm_pkg::LoadBits) begin
        load_shift_d = slbm_pkg::LoadShiftInit;
        load_count_d = 3'd0;
        unique case (in_item_i.bus_addr[14:13])
          slbm_pkg::RegControl: control_d  = shift_next;
          slbm_pkg::RegChrLow:  chr_low_d  = shift_next;
          slbm_pkg::RegChrHigh: chr_high_d = shift_next;
          slbm_pkg::RegPrg:     prg_sel_d  = shift_next[3:0];
          default:              prg_sel_d  = shift_next[3:0];
        endcase
      end else begin
        load_shift_d = shift_next;
        load_count_d = count_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_shift_q <= slbm_pkg::LoadShiftInit;
      load_count_q <= 3'd0;
      control_q    <= slbm_pkg::ControlInit;
      chr_low_q    <= 5'd0;
      chr_high_q   <= 5'd0;
      prg_sel_q    <= 4'd0;
    end else begin
      load_shift_q <= load_shift_d;
      load_count_q <= load_count_d;
      control_q    <= control_d;
      chr_low_q    <= chr_low_d;
      chr_high_q   <= chr_high_d;
      prg_sel_q    <= prg_sel_d;
    end
  end

  // One restoring remainder step of the shared compare and subtract unit.
  assign trial = {rem_q, dvd_q[4]};

  // Sequencer: decode at acceptance, five remainder steps, then hold the result.
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    dvd_d        = dvd_q;
    div_d        = div_q;
    rem_d        = rem_q;
    fixed_d      = fixed_q;
    fixed_bank_d = fixed_bank_q;
    offset_d     = offset_q;
    chr_d        = chr_q;
    hit_d        = hit_q;
    unique case (state_q)
      slbm_pkg::StIdle: begin
        if (in_acc) begin
          state_d      = slbm_pkg::StCalc;
          step_d       = 3'd0;
          rem_d        = 7'd0;
          dvd_d        = 5'd0;
          div_d        = 7'd1;
          fixed_d      = 1'b1;
          fixed_bank_d = 6'd0;
          offset_d     = 15'd0;
          chr_d        = 1'b0;
          hit_d        = 1'b0;
          unique case (in_item_i.action)
            slbm_pkg::ActCpuRead: begin
              if (in_item_i.bus_addr[15]) begin
                hit_d = 1'b1;
                div_d = prg_div;
                unique case (control_q[3:2])
                  slbm_pkg::PrgWideA, slbm_pkg::PrgWideB: begin
                    fixed_d  = 1'b0;
                    dvd_d    = {1'b0, prg_sel_q[3:1], 1'b0};
                    offset_d = in_item_i.bus_addr[14:0];
                  end
                  slbm_pkg::PrgFixFirst: begin
                    fixed_d  = !in_item_i.bus_addr[14];
                    dvd_d    = {1'b0, prg_sel_q};
                    offset_d = {1'b0, in_item_i.bus_addr[13:0]};
                  end
                  default: begin
                    fixed_d      = in_item_i.bus_addr[14];
                    fixed_bank_d = 6'(prg_div - 7'd1);
                    dvd_d        = {1'b0, prg_sel_q};
                    offset_d     = {1'b0, in_item_i.bus_addr[13:0]};
                  end
                endcase
              end
            end
            slbm_pkg::ActCpuWrite: begin
              hit_d = in_item_i.bus_addr[15];
            end
            slbm_pkg::ActPpuRead: begin
              if (in_item_i.bus_addr[15:13] == 3'd0) begin
                hit_d = 1'b1;
                chr_d = 1'b1;
                if (chr_count_q == 6'd0) begin
                  offset_d = {2'd0, in_item_i.bus_addr[12:0]};
                end else if (!control_q[4]) begin
                  fixed_d  = 1'b0;
                  div_d    = chr_div;
                  dvd_d    = {chr_low_q[4:1], 1'b0};
                  offset_d = {2'd0, in_item_i.bus_addr[12:0]};
                end else begin
                  fixed_d  = 1'b0;
                  div_d    = chr_div;
                  dvd_d    = in_item_i.bus_addr[12] ? chr_high_q : chr_low_q;
                  offset_d = {3'd0, in_item_i.bus_addr[11:0]};
                end
              end
            end
            default: begin
              // Only pattern RAM takes PPU writes, untranslated.
              if (in_item_i.bus_addr[15:13] == 3'd0 && chr_count_q == 6'd0) begin
                hit_d    = 1'b1;
                chr_d    = 1'b1;
                offset_d = {2'd0, in_item_i.bus_addr[12:0]};
              end
            end
          endcase
        end
      end
      slbm_pkg::StCalc: begin
        rem_d  = (trial >= {1'b0, div_q}) ? 7'(trial - {1'b0, div_q}) : trial[6:0];
        dvd_d  = {dvd_q[3:0], 1'b0};
        step_d = step_q + 3'd1;
        if (step_q == 3'(slbm_pkg::DivSteps - 1)) begin
          state_d = slbm_pkg::StDone;
        end
      end
      slbm_pkg::StDone: begin
        if (out_acc) begin
          state_d = slbm_pkg::StIdle;
        end
      end
      default: begin
        state_d = slbm_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slbm_pkg::StIdle;
      step_q  <= 3'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Datapath registers of the item in flight.
  always_ff @(posedge clk_i) begin
    dvd_q        <= dvd_d;
    div_q        <= div_d;
    rem_q        <= rem_d;
    fixed_q      <= fixed_d;
    fixed_bank_q <= fixed_bank_d;
    offset_q     <= offset_d;
    chr_q        <= chr_d;
    hit_q        <= hit_d;
  end

  // Result assembly: bank times unit size plus offset, wrapped to 19 bits.
  assign bank       = fixed_q ? {1'b0, fixed_bank_q} : rem_q;
  assign mapped_sum = (chr_q ? {2'd0, bank, 12'd0} : {bank, 14'd0}) + {6'd0, offset_q};

  assign out_item_o.hit         = hit_q;
  assign out_item_o.mapped_addr = mapped_sum[18:0];
  assign out_item_o.mirror_mode = control_q[1:0];

  // Checks on the sequencer and the remainder unit.
  `ASSERT_CLK(a_no_accept_with_result, out_valid_o |-> in_stall_o, "item taken past result")
  `ASSERT_CLK(a_accept_starts_calc, in_acc |=> state_q == slbm_pkg::StCalc, "item not started")
  `ASSERT_CLK(a_rem_below_div, state_q != slbm_pkg::StIdle |-> rem_q < div_q, "rem not reduced")
  `ASSERT_NEVER(a_load_count_range, load_count_q >= slbm_pkg::LoadBits, "loader overran")

endmodule

`default_nettype wire

/* test/serial_loaded_bank_mapper_tb.sv */
// Self-checking testbench of the serial loaded bank mapper: directed, random and stall tests.
module serial_loaded_bank_mapper_tb;

  // Configuration indexes that the block does not decode.
  localparam logic [slbm_pkg::CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [slbm_pkg::CfgIdxW-1:0] CfgSpareB = 2'd3;

  // A CPU write with this bit set clears the serial loader.
  localparam logic [7:0] LoaderClear = 8'h80;

  localparam int unsigned LongHold      = 300;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned SettleCycles  = 12;
  localparam int unsigned PhaseItems    = 80;

  logic clk_i;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  slbm_pkg::in_item_t            in_item = '0;
  logic                          in_stall;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  slbm_pkg::out_item_t           out_item;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [slbm_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [slbm_pkg::CfgDataW-1:0] cfg_data = '0;

  // Mirror of the mapper's registers, advanced as each item is accepted.
  logic [5:0] prg_count_q = 6'd1;
  logic [5:0] chr_count_q = 6'd0;
  logic [4:0] shift_q     = slbm_pkg::LoadShiftInit;
  logic [2:0] nbits_q     = 3'd0;
  logic [4:0] ctrl_q      = slbm_pkg::ControlInit;
  logic [4:0] chr_lo_q    = 5'd0;
  logic [4:0] chr_hi_q    = 5'd0;
  logic [3:0] prg_q       = 4'd0;

  slbm_pkg::out_item_t mapped_results_q[$];

  bit steady = 1'b0;
  logic long_hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_loads = 0;
  int unsigned n_cfg_writes = 0;
  int unsigned n_settings = 0;

  serial_loaded_bank_mapper i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Computes the result of one bus access and advances the mirrored registers.
  function automatic slbm_pkg::out_item_t map_bus_access(slbm_pkg::in_item_t a);
    slbm_pkg::out_item_t r;
    int unsigned banks;
    int unsigned units;
    int unsigned bank;
    int unsigned offs;
    r = '0;
    bank = 0;
    offs = 0;
    case (a.action)
      slbm_pkg::ActCpuRead: begin
        if (a.bus_addr[15]) begin
          banks = (prg_count_q == 6'd0) ? 1 : prg_count_q;
          r.hit = 1'b1;
          case (ctrl_q[3:2])
            slbm_pkg::PrgFixFirst: begin
              bank = a.bus_addr[14] ? prg_q % banks : 0;
              offs = a.bus_addr[13:0];
            end
            slbm_pkg::PrgFixLast: begin
              bank = a.bus_addr[14] ? banks - 1 : prg_q % banks;
              offs = a.bus_addr[13:0];
            end
            default: begin
              bank = (prg_q & 4'he) % banks;
              offs = a.bus_addr[14:0];
            end
          endcase
          r.mapped_addr = 19'(bank * 32'h4000 + offs);
        end
      end
      slbm_pkg::ActCpuWrite: begin
        if (a.bus_addr[15]) begin
          r.hit = 1'b1;
          if (a.write_data[7]) begin
            shift_q = slbm_pkg::LoadShiftInit;
            nbits_q = 3'd0;
            ctrl_q = ctrl_q | 5'h0c;
          end else begin
            shift_q = {a.write_data[0], shift_q[4:1]};
            nbits_q = nbits_q + 3'd1;
            if (nbits_q == slbm_pkg::LoadBits) begin
              case (a.bus_addr[14:13])
                slbm_pkg::RegControl: ctrl_q = shift_q;
                slbm_pkg::RegChrLow:  chr_lo_q = shift_q;
                slbm_pkg::RegChrHigh: chr_hi_q = shift_q;
                default:              prg_q = shift_q[3:0];
              endcase
              shift_q = slbm_pkg::LoadShiftInit;
              nbits_q = 3'd0;
            end
          end
        end
      end
      slbm_pkg::ActPpuRead: begin
        if (a.bus_addr[15:13] == 3'd0) begin
          r.hit = 1'b1;
          if (chr_count_q == 6'd0) begin
            r.mapped_addr = 19'(a.bus_addr);
          end else begin
            units = 2 * chr_count_q;
            if (!ctrl_q[4]) begin
              bank = (chr_lo_q & 5'h1e) % units;
              offs = a.bus_addr[12:0];
            end else begin
              bank = (a.bus_addr[12] ? chr_hi_q : chr_lo_q) % units;
              offs = a.bus_addr[11:0];
            end
            r.mapped_addr = 19'(bank * 32'h1000 + offs);
          end
        end
      end
      default: begin
        // Pattern RAM writes pass through; pattern ROM and other addresses are not claimed.
        if (a.bus_addr[15:13] == 3'd0 && chr_count_q == 6'd0) begin
          r.hit = 1'b1;
          r.mapped_addr = 19'(a.bus_addr);
        end
      end
    endcase
    r.mirror_mode = ctrl_q[1:0];
    return r;
  endfunction

  // Offers one item, after a random gap outside steady phases, and records its result once accepted.
  task automatic send_access(slbm_pkg::in_item_t a);
    while (!steady && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= a;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    mapped_results_q.push_back(map_bus_access(a));
    n_items++;
  endtask

  task automatic send_fields(logic [1:0] action, logic [15:0] addr, logic [7:0] data);
    slbm_pkg::in_item_t a;
    a.action = action;
    a.bus_addr = addr;
    a.write_data = data;
    send_access(a);
  endtask

  // Stops offering items and waits until every result has come back.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (mapped_results_q.size() != 0) @(posedge clk_i);
  endtask

  // Holds one register write until it is taken; the caller lowers the valid.
  task automatic write_reg(logic [slbm_pkg::CfgIdxW-1:0] idx,
                           logic [slbm_pkg::CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    case (idx)
      slbm_pkg::CfgPrgCount: prg_count_q = val;
      slbm_pkg::CfgChrCount: chr_count_q = val;
      default: ;
    endcase
    n_cfg_writes++;
  endtask

  task automatic set_bank_counts(logic [5:0] prg, logic [5:0] chr);
    wait_results_done();
    write_reg(slbm_pkg::CfgPrgCount, prg);
    write_reg(slbm_pkg::CfgChrCount, chr);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Shifts a five-bit value into the register chosen by address bits 14:13.
  task automatic load_register(logic [1:0] target, logic [4:0] value);
    for (int b = 0; b < 5; b++) begin
      send_fields(slbm_pkg::ActCpuWrite, {1'b1, target, 13'($urandom)},
                  {1'b0, 6'($urandom), value[b]});
    end
    n_loads++;
  endtask

  // One access, mostly in the claimed windows.
  task automatic mapped_access();
    case ($urandom_range(3))
      0: send_fields(slbm_pkg::ActCpuRead, {1'b1, 15'($urandom)}, 8'($urandom));
      1: send_fields(slbm_pkg::ActPpuRead, {3'b000, 13'($urandom)}, 8'($urandom));
      2: send_fields(slbm_pkg::ActPpuWrite, {3'b000, 13'($urandom)}, 8'($urandom));
      default: send_fields(2'($urandom), 16'($urandom), 8'($urandom));
    endcase
  endtask

  // A load cut short by a loader clear.
  task automatic broken_load();
    int unsigned bits;
    bits = $urandom_range(1, 4);
    for (int b = 0; b < bits; b++) begin
      send_fields(slbm_pkg::ActCpuWrite, {1'b1, 15'($urandom)}, {1'b0, 7'($urandom)});
    end
    send_fields(slbm_pkg::ActCpuWrite, {1'b1, 15'($urandom)}, LoaderClear | 8'($urandom));
  endtask

  // Accesses at reset values: both windows, their edges and unclaimed cases.
  task automatic test_reset_state();
    send_fields(slbm_pkg::ActCpuRead, 16'h8000, 8'h00);
    send_fields(slbm_pkg::ActCpuRead, 16'hffff, 8'hff);
    send_fields(slbm_pkg::ActCpuRead, 16'h7fff, 8'h00);
    send_fields(slbm_pkg::ActPpuRead, 16'h0000, 8'h00);
    send_fields(slbm_pkg::ActPpuRead, 16'h1fff, 8'h00);
    send_fields(slbm_pkg::ActPpuRead, 16'h2000, 8'h00);
    send_fields(slbm_pkg::ActPpuWrite, 16'h1fff, 8'hff);
    send_fields(slbm_pkg::ActPpuWrite, 16'hffff, 8'h00);
    send_fields(slbm_pkg::ActCpuWrite, 16'h0000, 8'hff);
    send_fields(slbm_pkg::ActCpuWrite, 16'hffff, LoaderClear);
  endtask

  // Full serial load of the control register, then accesses with split CHR and 32 KiB PRG banking and a loader clear.
  task automatic test_serial_load();
    set_bank_counts(6'd32, 6'd32);
    load_register(slbm_pkg::RegControl, 5'h13);
    send_fields(slbm_pkg::ActCpuRead, 16'hc000, 8'h00);
    send_fields(slbm_pkg::ActPpuRead, 16'h0fff, 8'h00);
    send_fields(slbm_pkg::ActPpuRead, 16'h1000, 8'h00);
    send_fields(slbm_pkg::ActPpuWrite, 16'h0000, 8'h00);
    send_fields(slbm_pkg::ActCpuWrite, 16'he000, 8'h01);
    send_fields(slbm_pkg::ActCpuWrite, 16'he000, LoaderClear);
    send_fields(slbm_pkg::ActCpuRead, 16'h8000, 8'h00);
  endtask

  // Writes to undecoded indexes must leave the bank counts alone.
  task automatic test_spare_index();
    set_bank_counts(6'd5, 6'd3);
    write_reg(CfgSpareA, 6'h3f);
    write_reg(CfgSpareB, 6'h00);
    cfg_valid <= 1'b0;
    load_register(slbm_pkg::RegPrg, 5'h1f);
    load_register(slbm_pkg::RegChrLow, 5'h1f);
    repeat (6) mapped_access();
  endtask

  // Random phases over several bank count settings, extremes included.
  task automatic test_random_phases();
    int prg_set[6];
    int chr_set[6];
    int unsigned goal;
    int unsigned pick;
    prg_set = '{1, 32, 0, 63, 7, 1};
    chr_set = '{0, 32, 1, 63, 0, 0};
    prg_set[5] = $urandom_range(2, 32);
    chr_set[5] = $urandom_range(0, 32);
    for (int ph = 0; ph < 6; ph++) begin
      set_bank_counts(6'(prg_set[ph]), 6'(chr_set[ph]));
      steady = (ph == 2);
      goal = n_items + PhaseItems;
      while (n_items < goal) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          load_register(2'($urandom), 5'($urandom));
        end else if (pick < 48) begin
          send_fields(slbm_pkg::ActCpuWrite, {1'b1, 15'($urandom)},
                      LoaderClear | 8'($urandom));
        end else if (pick < 85) begin
          repeat (3) mapped_access();
        end else if (pick < 92) begin
          broken_load();
        end else begin
          send_fields(2'($urandom), 16'($urandom), 8'($urandom));
        end
      end
    end
    steady = 1'b0;
  endtask

  // The receiver holds off while items keep coming, then the sender drains.
  task automatic test_back_pressure();
    long_hold_req <= 1'b1;
    repeat (15) mapped_access();
    wait_results_done();
  endtask

  // Result checker and receiver stall, including the long hold-off.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (mapped_results_q.size() == 0) begin
          $error("unexpected result item: hit %0d, mapped_addr 0x%05h, mirror_mode %0d",
                 out_item.hit, out_item.mapped_addr, out_item.mirror_mode);
          mismatches++;
        end else begin
          slbm_pkg::out_item_t want;
          want = mapped_results_q.pop_front();
          if (out_item.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, out_item.hit);
            mismatches++;
          end
          if (out_item.mapped_addr !== want.mapped_addr) begin
            $error("mapped_addr: expected 0x%05h, got 0x%05h",
                   want.mapped_addr, out_item.mapped_addr);
            mismatches++;
          end
          if (out_item.mirror_mode !== want.mirror_mode) begin
            $error("mirror_mode: expected %0d, got %0d", want.mirror_mode, out_item.mirror_mode);
            mismatches++;
          end
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (long_hold_req) begin
        out_stall <= 1'b1;
        hold_left <= LongHold;
        long_hold_req <= 1'b0;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 20);
      end
    end
  end

  // Watchdog on cycles with no handshake on any channel.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_serial_load();
    test_spare_index();
    test_random_phases();
    test_back_pressure();
    wait_results_done();
    repeat (SettleCycles) @(posedge clk_i);
    $display("Covered %0d bus accesses (%0d results) with %0d serial loads,",
             n_items, n_results, n_loads);
    $display("%0d register writes over %0d bank count settings and a long output stall.",
             n_cfg_writes, n_settings);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
